@@ rtl/sine_dds_led_colour_cycler_core_assert.svh @@
// assertion macros used by the colour cycler top level
`ifndef SINE_DDS_LED_COLOUR_CYCLER_CORE_ASSERT_SVH
`define SINE_DDS_LED_COLOUR_CYCLER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SDLCC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define SDLCC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/sdlcc_pkg.sv @@
// shared types, constants and sine table of the colour cycler
package sdlcc_pkg;

   localparam int SLOTS_DEFAULT = 4;
   localparam int TABLE_DEPTH   = 128;
   localparam int SLOT_CAP      = 4;

   // configuration register indexes
   localparam logic [2:0] REG_RED_STEPS   = 3'd0;
   localparam logic [2:0] REG_GREEN_STEPS = 3'd1;
   localparam logic [2:0] REG_BLUE_STEPS  = 3'd2;
   localparam logic [2:0] REG_LEVEL_STEPS = 3'd3;
   localparam logic [2:0] REG_SHORT_TICKS = 3'd4;
   localparam logic [2:0] REG_LONG_TICKS  = 3'd5;

   localparam logic [31:0] RED_STEPS_RST   = 32'h0F1F_3E7D;
   localparam logic [31:0] GREEN_STEPS_RST = 32'h1117_2F5D;
   localparam logic [31:0] BLUE_STEPS_RST  = 32'h0307_0D1A;
   localparam logic [31:0] LEVEL_STEPS_RST = 32'h0000_0000;
   localparam logic [7:0]  SHORT_TICKS_RST = 8'd5;
   localparam logic [7:0]  LONG_TICKS_RST  = 8'd25;

   localparam logic [15:0] PHASE_RED_RST   = 16'(111 << 8);
   localparam logic [15:0] PHASE_GREEN_RST = 16'(86 << 8);
   localparam logic [15:0] PHASE_BLUE_RST  = 16'(98 << 8);
   localparam logic [15:0] PHASE_LEVEL_RST = 16'd0;

   localparam logic [7:0] HOLD_MAX = 8'hFF;

   typedef struct packed {
      logic [31:0] red_steps;
      logic [31:0] green_steps;
      logic [31:0] blue_steps;
      logic [31:0] level_steps;
      logic [7:0]  short_ticks;
      logic [7:0]  long_ticks;
   } cfg_type;

   typedef struct packed {
      logic       blank;
      logic       save;
      logic       mode_step;
      logic [2:0] mode_next;
      logic [1:0] slot;
   } ctl_type;

   typedef struct packed {
      logic [4:0] level;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } colour_type;

   // one period of a raised sine, offset 0x78, peak 0xef
   localparam logic [7:0] SINE_ROM [TABLE_DEPTH] = '{
      8'h78, 8'h7D, 8'h83, 8'h89, 8'h8F, 8'h94, 8'h9A, 8'hA0,
      8'hA5, 8'hAA, 8'hB0, 8'hB5, 8'hBA, 8'hBE, 8'hC3, 8'hC7,
      8'hCC, 8'hD0, 8'hD3, 8'hD7, 8'hDA, 8'hDE, 8'hE0, 8'hE3,
      8'hE5, 8'hE8, 8'hE9, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEE,
      8'hEF, 8'hEE, 8'hEE, 8'hED, 8'hEC, 8'hEB, 8'hE9, 8'hE8,
      8'hE5, 8'hE3, 8'hE0, 8'hDE, 8'hDA, 8'hD7, 8'hD3, 8'hD0,
      8'hCC, 8'hC7, 8'hC3, 8'hBE, 8'hBA, 8'hB5, 8'hB0, 8'hAA,
      8'hA5, 8'hA0, 8'h9A, 8'h94, 8'h8F, 8'h89, 8'h83, 8'h7D,
      8'h78, 8'h73, 8'h6D, 8'h67, 8'h61, 8'h5C, 8'h56, 8'h50,
      8'h4B, 8'h46, 8'h40, 8'h3B, 8'h36, 8'h32, 8'h2D, 8'h29,
      8'h24, 8'h20, 8'h1D, 8'h19, 8'h16, 8'h12, 8'h10, 8'h0D,
      8'h0B, 8'h08, 8'h07, 8'h05, 8'h04, 8'h03, 8'h02, 8'h02,
      8'h00, 8'h02, 8'h02, 8'h03, 8'h04, 8'h05, 8'h07, 8'h08,
      8'h0B, 8'h0D, 8'h10, 8'h12, 8'h16, 8'h19, 8'h1D, 8'h20,
      8'h24, 8'h29, 8'h2D, 8'h32, 8'h36, 8'h3B, 8'h40, 8'h46,
      8'h4B, 8'h50, 8'h56, 8'h5C, 8'h61, 8'h67, 8'h6D, 8'h73
   };

endpackage

@@ rtl/sine_dds_led_colour_cycler_core.sv @@
// top level of the sine colour cycler with its result register
//
//  channel  dir  handshake               payload
//  req      in   req_tvalid/req_tready   req_tdata[0] button_pressed
//  rsp      out  rsp_tvalid/rsp_tready   rsp_tdata red, green, blue, brightness
//  csr      in   csr_valid/csr_ready     csr_index, csr_data
//
// one tick per clock: each req transaction is worked out in the cycle it is
// taken and its colour lands in the rsp register at that edge
// the rsp register is the only stage, so req_tready stays high while it is
// empty or being drained in the same cycle
// a stalled rsp holds its data and blocks new ticks until taken
// reset is synchronous; csr_ready is always high
`include "sine_dds_led_colour_cycler_core_assert.svh"

module sine_dds_led_colour_cycler_core #(
   parameter int SLOTS = sdlcc_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [0] button_pressed, [7:1] zero
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // rsp_tdata: [7:0] red, [15:8] green, [23:16] blue, [28:24] brightness,
   // [31:29] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   import sdlcc_pkg::*;

   cfg_type     cfg;
   ctl_type     ctl;
   colour_type  colour;
   logic        accept;
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   // take a tick whenever the result register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   sdlcc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sdlcc_press #(
      .SLOTS (SLOTS)
   ) u_press (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .pressed     (req_tdata[0]),
      .short_ticks (cfg.short_ticks),
      .long_ticks  (cfg.long_ticks),
      .ctl         (ctl)
   );

   sdlcc_colour u_colour (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .ctl    (ctl),
      .cfg    (cfg),
      .colour (colour)
   );

   // blank ticks give all zero, otherwise the fresh colour
   assign rsp_data_in = ctl.blank ? 32'd0 :
                        {3'd0, colour.level, colour.blue, colour.green, colour.red};

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks on tick handling
   `SDLCC_ASSERT_NEXT(a_tick_loads, accept, rsp_tvalid, "accepted tick gave no result")
   `SDLCC_ASSERT_NEXT(a_blank_zero, accept && ctl.blank, rsp_tdata == 32'd0,
                      "blank tick gave a nonzero colour")
   `SDLCC_ASSERT_SAME(a_save_blank, ctl.save, ctl.blank, "slot save on a lit tick")
   `SDLCC_ASSERT_SAME(a_step_lit, ctl.mode_step, !ctl.blank && !ctl.save,
                      "mode advance on a blank tick")

endmodule

@@ rtl/sdlcc_csr.sv @@
// configuration registers of the colour cycler
module sdlcc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   output sdlcc_pkg::cfg_type cfg
);
   import sdlcc_pkg::*;

   cfg_type cfg_ff;
   logic    wr_en;

   assign csr_ready = 1'b1;
   assign wr_en     = csr_valid && csr_ready;
   assign cfg       = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.red_steps   <= RED_STEPS_RST;
         cfg_ff.green_steps <= GREEN_STEPS_RST;
         cfg_ff.blue_steps  <= BLUE_STEPS_RST;
         cfg_ff.level_steps <= LEVEL_STEPS_RST;
         cfg_ff.short_ticks <= SHORT_TICKS_RST;
         cfg_ff.long_ticks  <= LONG_TICKS_RST;
      end else if (wr_en) begin
         case (csr_index)
            REG_RED_STEPS:   cfg_ff.red_steps   <= csr_data;
            REG_GREEN_STEPS: cfg_ff.green_steps <= csr_data;
            REG_BLUE_STEPS:  cfg_ff.blue_steps  <= csr_data;
            REG_LEVEL_STEPS: cfg_ff.level_steps <= csr_data;
            REG_SHORT_TICKS: cfg_ff.short_ticks <= csr_data[7:0];
            REG_LONG_TICKS:  cfg_ff.long_ticks  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

endmodule

@@ rtl/sdlcc_press.sv @@
// button press tracker: hold counter, press phase, mode and save slot
module sdlcc_press #(
   parameter int SLOTS = sdlcc_pkg::SLOTS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic               pressed,
   input  logic [7:0]         short_ticks,
   input  logic [7:0]         long_ticks,
   output sdlcc_pkg::ctl_type ctl
);
   import sdlcc_pkg::*;

   localparam logic [1:0] PH_IDLE  = 2'd0;
   localparam logic [1:0] PH_BLANK = 2'd1;
   localparam logic [1:0] PH_WAIT  = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [7:0] hold_ff, hold_in;
   logic [2:0] mode_ff, mode_in;
   logic [1:0] slot_ff, slot_in;
   logic [2:0] slot_sum;
   logic       blank, save, mode_step;

   assign slot_sum = {1'b0, slot_ff} + 3'd1;

   always_comb begin
      phase_in  = phase_ff;
      hold_in   = hold_ff;
      mode_in   = mode_ff;
      slot_in   = slot_ff;
      blank     = 1'b0;
      save      = 1'b0;
      mode_step = 1'b0;
      if (phase_ff == PH_WAIT) begin
         if (pressed) begin
            blank = 1'b1;
         end else begin
            phase_in = PH_IDLE;
         end
      end else begin
         if (pressed) begin
            if (hold_ff != HOLD_MAX) begin
               hold_in = hold_ff + 8'd1;
            end
         end else if (phase_ff != PH_BLANK) begin
            hold_in = 8'd0;
         end
         // idle and the spare code both behave as idle
         if (phase_ff != PH_BLANK) begin
            phase_in = (hold_in > short_ticks) ? PH_BLANK : PH_IDLE;
         end
         if (phase_in == PH_BLANK) begin
            if (hold_in > long_ticks) begin
               save     = 1'b1;
               slot_in  = (slot_sum >= 3'(SLOTS)) ? 2'd0 : slot_sum[1:0];
               hold_in  = 8'd0;
               phase_in = PH_WAIT;
               blank    = 1'b1;
            end else if (!pressed) begin
               mode_step = 1'b1;
               mode_in   = mode_ff + 3'd1;
               hold_in   = 8'd0;
               phase_in  = PH_IDLE;
            end else begin
               blank = 1'b1;
            end
         end
      end
   end

   assign ctl.blank     = blank;
   assign ctl.save      = save;
   assign ctl.mode_step = mode_step;
   assign ctl.mode_next = mode_in;
   assign ctl.slot      = slot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         hold_ff  <= 8'd0;
         mode_ff  <= 3'd0;
         slot_ff  <= 2'd0;
      end else if (accept) begin
         phase_ff <= phase_in;
         hold_ff  <= hold_in;
         mode_ff  <= mode_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

@@ rtl/sdlcc_colour.sv @@
// phase accumulators, sine lookup, current colour and saved colour slots
module sdlcc_colour (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  sdlcc_pkg::ctl_type    ctl,
   input  sdlcc_pkg::cfg_type    cfg,
   output sdlcc_pkg::colour_type colour
);
   import sdlcc_pkg::*;

   logic [15:0] ph_red_ff, ph_green_ff, ph_blue_ff, ph_level_ff;
   logic [15:0] ph_red_in, ph_green_in, ph_blue_in, ph_level_in;
   colour_type  cur_ff, cur_in;
   colour_type  saved_ff [SLOT_CAP];
   logic [1:0]  sel;
   logic        dds_mode;

   assign sel      = ctl.mode_next[1:0];
   assign dds_mode = !ctl.mode_next[2];

   assign ph_red_in   = ph_red_ff   + {8'd0, cfg.red_steps[{sel, 3'b000} +: 8]};
   assign ph_green_in = ph_green_ff + {8'd0, cfg.green_steps[{sel, 3'b000} +: 8]};
   assign ph_blue_in  = ph_blue_ff  + {8'd0, cfg.blue_steps[{sel, 3'b000} +: 8]};
   assign ph_level_in = ph_level_ff + {8'd0, cfg.level_steps[{sel, 3'b000} +: 8]};

   always_comb begin
      if (dds_mode) begin
         cur_in.red   = SINE_ROM[ph_red_in[14:8]];
         cur_in.green = SINE_ROM[ph_green_in[14:8]];
         cur_in.blue  = SINE_ROM[ph_blue_in[14:8]];
         cur_in.level = SINE_ROM[ph_level_in[14:8]][7:3];
      end else begin
         cur_in = saved_ff[sel];
      end
   end

   assign colour = cur_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_red_ff   <= PHASE_RED_RST;
         ph_green_ff <= PHASE_GREEN_RST;
         ph_blue_ff  <= PHASE_BLUE_RST;
         ph_level_ff <= PHASE_LEVEL_RST;
         cur_ff      <= '0;
      end else if (accept && !ctl.blank) begin
         cur_ff <= cur_in;
         if (dds_mode) begin
            ph_red_ff   <= ph_red_in;
            ph_green_ff <= ph_green_in;
            ph_blue_ff  <= ph_blue_in;
            ph_level_ff <= ph_level_in;
         end
      end
   end

   // slot store, written only on a long press
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLOT_CAP; k++) begin
            saved_ff[k].red   <= 8'hFF;
            saved_ff[k].green <= 8'hFF;
            saved_ff[k].blue  <= 8'hFF;
            saved_ff[k].level <= 5'(8 * k + 7);
         end
      end else if (accept && ctl.save) begin
         saved_ff[ctl.slot] <= cur_ff;
      end
   end

endmodule

@@ tb/sv/sine_dds_led_colour_cycler_core_tb.sv @@
// self-checking testbench for the sine colour cycler core
module sine_dds_led_colour_cycler_core_tb;

   import sdlcc_pkg::*;

   localparam int SLOT_COUNT  = SLOTS_DEFAULT;
   localparam int QUIET_LIMIT = 2000;   // cycles with no transaction on any channel
   localparam int HOLD_OFF    = 40;     // long rsp stall, fills the result register
   localparam int PRINT_CAP   = 40;

   // phase accumulator lanes, same order as the step registers
   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_LEVEL = 3;

   typedef enum logic [1:0] {PRESS_IDLE, PRESS_BLANK, PRESS_WAIT} press_e;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_THIRD} stall_e;

   // raised sine, one period over 128 entries
   localparam bit [7:0] SINE_LUT [128] = '{
      8'h78, 8'h7D, 8'h83, 8'h89, 8'h8F, 8'h94, 8'h9A, 8'hA0,
      8'hA5, 8'hAA, 8'hB0, 8'hB5, 8'hBA, 8'hBE, 8'hC3, 8'hC7,
      8'hCC, 8'hD0, 8'hD3, 8'hD7, 8'hDA, 8'hDE, 8'hE0, 8'hE3,
      8'hE5, 8'hE8, 8'hE9, 8'hEB, 8'hEC, 8'hED, 8'hEE, 8'hEE,
      8'hEF, 8'hEE, 8'hEE, 8'hED, 8'hEC, 8'hEB, 8'hE9, 8'hE8,
      8'hE5, 8'hE3, 8'hE0, 8'hDE, 8'hDA, 8'hD7, 8'hD3, 8'hD0,
      8'hCC, 8'hC7, 8'hC3, 8'hBE, 8'hBA, 8'hB5, 8'hB0, 8'hAA,
      8'hA5, 8'hA0, 8'h9A, 8'h94, 8'h8F, 8'h89, 8'h83, 8'h7D,
      8'h78, 8'h73, 8'h6D, 8'h67, 8'h61, 8'h5C, 8'h56, 8'h50,
      8'h4B, 8'h46, 8'h40, 8'h3B, 8'h36, 8'h32, 8'h2D, 8'h29,
      8'h24, 8'h20, 8'h1D, 8'h19, 8'h16, 8'h12, 8'h10, 8'h0D,
      8'h0B, 8'h08, 8'h07, 8'h05, 8'h04, 8'h03, 8'h02, 8'h02,
      8'h00, 8'h02, 8'h02, 8'h03, 8'h04, 8'h05, 8'h07, 8'h08,
      8'h0B, 8'h0D, 8'h10, 8'h12, 8'h16, 8'h19, 8'h1D, 8'h20,
      8'h24, 8'h29, 8'h2D, 8'h32, 8'h36, 8'h3B, 8'h40, 8'h46,
      8'h4B, 8'h50, 8'h56, 8'h5C, 8'h61, 8'h67, 8'h6D, 8'h73
   };

   // colour predictor plus the queue of colours still owed by the block
   class colour_scoreboard;
      bit [31:0]  steps [4];
      bit [7:0]   short_ticks;
      bit [7:0]   long_ticks;
      bit [2:0]   mode;
      bit [1:0]   slot;
      bit [7:0]   hold_count;
      press_e     press;
      bit [15:0]  phase [4];
      colour_type current;
      colour_type saved [4];
      colour_type expected_colours [$];
      int         fail_count;

      function new();
         fail_count = 0;
         reset_state();
      endfunction

      function void reset_state();
         int k;
         steps       = '{32'h0F1F_3E7D, 32'h1117_2F5D, 32'h0307_0D1A, 32'h0000_0000};
         short_ticks = 8'd5;
         long_ticks  = 8'd25;
         mode        = '0;
         slot        = '0;
         hold_count  = '0;
         press       = PRESS_IDLE;
         phase       = '{16'h6F00, 16'h5600, 16'h6200, 16'h0000};
         current     = '0;
         for (k = 0; k < 4; k++) begin
            saved[k] = '{level: 5'(8 * k + 7), blue: 8'hFF, green: 8'hFF, red: 8'hFF};
         end
      endfunction

      function void write_reg(bit [2:0] index, bit [31:0] value);
         case (index)
            REG_RED_STEPS:   steps[CH_RED]   = value;
            REG_GREEN_STEPS: steps[CH_GREEN] = value;
            REG_BLUE_STEPS:  steps[CH_BLUE]  = value;
            REG_LEVEL_STEPS: steps[CH_LEVEL] = value;
            REG_SHORT_TICKS: short_ticks     = value[7:0];
            REG_LONG_TICKS:  long_ticks      = value[7:0];
            default: ;
         endcase
      endfunction

      // one update tick: press handling, then either blank or a fresh colour
      function colour_type advance_tick(bit pressed);
         bit blank;
         int lane;
         int c;
         blank = 1'b0;
         if (press == PRESS_WAIT) begin
            if (pressed) blank = 1'b1;
            else press = PRESS_IDLE;
         end else begin
            if (pressed) begin
               if (hold_count != 8'hFF) hold_count++;
            end else if (press != PRESS_BLANK) begin
               hold_count = '0;
            end
            if (press != PRESS_BLANK)
               press = (hold_count > short_ticks) ? PRESS_BLANK : PRESS_IDLE;
            if (press == PRESS_BLANK) begin
               if (hold_count > long_ticks) begin
                  saved[slot] = current;
                  slot        = (int'(slot) + 1 >= SLOT_COUNT) ? 2'd0 : slot + 2'd1;
                  hold_count  = '0;
                  press       = PRESS_WAIT;
                  blank       = 1'b1;
               end else if (!pressed) begin
                  mode++;
                  hold_count = '0;
                  press      = PRESS_IDLE;
               end else begin
                  blank = 1'b1;
               end
            end
         end
         if (blank) return '0;
         if (!mode[2]) begin
            lane = mode[1:0];
            for (c = 0; c < 4; c++) phase[c] += 16'(steps[c][lane * 8 +: 8]);
            current.red   = SINE_LUT[phase[CH_RED][14:8]];
            current.green = SINE_LUT[phase[CH_GREEN][14:8]];
            current.blue  = SINE_LUT[phase[CH_BLUE][14:8]];
            current.level = SINE_LUT[phase[CH_LEVEL][14:8]][7:3];
         end else begin
            current = saved[mode[1:0]];
         end
         return current;
      endfunction

      function void note_tick(bit pressed);
         expected_colours.push_back(advance_tick(pressed));
      endfunction

      function int pending();
         return expected_colours.size();
      endfunction

      function void report(string msg);
         fail_count++;
         if (fail_count <= PRINT_CAP) $display("mismatch: %s", msg);
      endfunction

      function void check_result(bit [31:0] data);
         colour_type got;
         colour_type want;
         if (expected_colours.size() == 0) begin
            report($sformatf("colour 0x%08h with no tick pending", data));
            return;
         end
         want = expected_colours.pop_front();
         got  = colour_type'(data[28:0]);
         if (got.red !== want.red)
            report($sformatf("red got %0d want %0d", got.red, want.red));
         if (got.green !== want.green)
            report($sformatf("green got %0d want %0d", got.green, want.green));
         if (got.blue !== want.blue)
            report($sformatf("blue got %0d want %0d", got.blue, want.blue));
         if (got.level !== want.level)
            report($sformatf("brightness got %0d want %0d", got.level, want.level));
         if (data[31:29] !== 3'b000)
            report($sformatf("padding bits got %b", data[31:29]));
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [0] button_pressed, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [7:0] red, [15:8] green, [23:16] blue, [28:24] brightness
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index  = '0;
   logic [31:0] csr_data   = '0;

   colour_scoreboard sb = new();

   int     ticks_sent   = 0;
   int     results_seen = 0;
   int     burst_left   = 0;
   int     quiet_cycles = 0;
   int     hold_left    = 0;
   bit     held_once    = 1'b0;
   int     seg_left     = 0;
   stall_e seg_kind     = STALL_NONE;

   sine_dds_led_colour_cycler_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // offer one tick; the sender runs in bursts with idle gaps between them
   task automatic send_tick(input bit pressed);
      if (burst_left == 0) begin
         // the gap always holds valid low at a clock edge, so valid never drops and rises in one step
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, pressed};
      do @(posedge clock); while (!req_tready);
      sb.note_tick(pressed);
      ticks_sent++;
      burst_left--;
   endtask

   task automatic press_for(input int n);
      repeat (n) send_tick(1'b1);
   endtask

   // stop offering and let every owed colour come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (2) @(posedge clock);
   endtask

   // csr_valid stays high across back-to-back writes, lowered once afterwards
   task automatic write_csr(input bit [2:0] index, input bit [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(index, value);
   endtask

   // threshold registers are 8 bits wide, junk in the upper bits must be dropped
   task automatic configure(input bit [31:0] red_s, input bit [31:0] green_s,
                            input bit [31:0] blue_s, input bit [31:0] level_s,
                            input bit [7:0] short_t, input bit [7:0] long_t);
      write_csr(REG_RED_STEPS, red_s);
      write_csr(REG_GREEN_STEPS, green_s);
      write_csr(REG_BLUE_STEPS, blue_s);
      write_csr(REG_LEVEL_STEPS, level_s);
      write_csr(REG_SHORT_TICKS, {24'($urandom), short_t});
      write_csr(REG_LONG_TICKS, {24'($urandom), long_t});
      csr_valid <= 1'b0;
   endtask

   // mostly release runs followed by presses sized around the thresholds,
   // with the odd burst of random button noise
   task automatic play_random(input int budget);
      int start;
      int cap;
      start = ticks_sent;
      cap   = ((sb.short_ticks > sb.long_ticks) ? sb.short_ticks : sb.long_ticks) + 3;
      if (cap > 40) cap = 40;
      while (ticks_sent - start < budget) begin
         if ($urandom_range(0, 7) == 0) begin
            repeat (6) send_tick(1'($urandom_range(0, 1)));
         end else begin
            repeat ($urandom_range(1, 3)) send_tick(1'b0);
            press_for($urandom_range(1, cap));
         end
      end
   endtask

   // rsp side: check each result transaction, then pick the next tready
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata);
         results_seen++;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!held_once && results_seen >= 120 && req_tvalid) begin
         // one long stall while ticks keep coming, so req_tready must drop
         held_once = 1'b1;
         hold_left = HOLD_OFF - 1;
         rsp_tready <= 1'b0;
      end else begin
         if (seg_left == 0) begin
            seg_kind = stall_e'($urandom_range(0, 2));
            seg_left = $urandom_range(10, 60);
         end
         seg_left--;
         case (seg_kind)
            STALL_NONE:   rsp_tready <= 1'b1;
            STALL_RANDOM: rsp_tready <= 1'($urandom_range(0, 1));
            default:      rsp_tready <= (seg_left % 3 == 0);
         endcase
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   initial begin
      int setting;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a press too short to be recognised
      send_tick(1'b0);
      press_for(3);
      send_tick(1'b0);

      // hair-trigger thresholds and extreme increments
      wait_drained();
      configure(32'hFFFF_FFFF, 32'h0000_0000, 32'h80FF_017F, 32'hFF80_0140, 8'd0, 8'd2);
      // long press saves mode 0 colour into slot 0, blank until release
      press_for(4);
      send_tick(1'b0);
      // short presses walk all eight modes and wrap back to 0
      repeat (8) begin
         send_tick(1'b1);
         send_tick(1'b0);
      end

      for (setting = 0; setting < 8; setting++) begin
         wait_drained();
         case (setting)
            0: configure($urandom, $urandom, $urandom, $urandom,
                         8'($urandom_range(1, 6)), 8'($urandom_range(7, 14)));
            // short above long: every recognised press is long
            1: configure($urandom, $urandom, $urandom, $urandom, 8'd3, 8'd1);
            // both zero: first pressed tick saves
            2: configure($urandom, $urandom, $urandom, $urandom, 8'd0, 8'd0);
            // zero increments: phases frozen
            3: configure('0, '0, '0, '0, 8'd2, 8'd5);
            4: configure('1, '1, '1, '1, 8'd1, 8'd4);
            // no press recognised, hold count saturates
            5: configure($urandom, $urandom, $urandom, $urandom, 8'd255, 8'd255);
            6: configure($urandom, $urandom, $urandom, $urandom,
                         8'($urandom_range(0, 3)), 8'($urandom_range(0, 10)));
            default: configure($urandom, $urandom, $urandom, $urandom, 8'd5, 8'd25);
         endcase
         if (setting == 5) begin
            press_for(262);
            send_tick(1'b0);
         end
         play_random(12);
      end

      wait_drained();
      repeat (4) @(posedge clock);
      if (sb.fail_count == 0 && sb.pending() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

@@ sine_dds_led_colour_cycler_core.f @@
+incdir+rtl
rtl/sdlcc_pkg.sv
rtl/sdlcc_csr.sv
rtl/sdlcc_press.sv
rtl/sdlcc_colour.sv
rtl/sine_dds_led_colour_cycler_core.sv
tb/sv/sine_dds_led_colour_cycler_core_tb.sv
